>>> src/wphg_pkg.sv
// Package: types, constants and tables for the waypoint heading guidance block.
`default_nettype none
package wphg_pkg;
   localparam int CORDIC_STEPS  = 16;
   localparam int NUM_WAYPOINTS = 3;
   localparam int StepW = $clog2(CORDIC_STEPS + 1);

   localparam logic [17:0] UPDATE_PERIOD = 18'd20000;
   localparam logic [17:0] ACCUM_MAX     = 18'h3FFFF;
   localparam logic [32:0] NEAR_SQ       = 33'd10000;
   localparam logic signed [15:0] GAIN_Q15 = 16'sd22938;
   localparam logic signed [39:0] CORDIC_K = 40'sd652032875;

   localparam logic [2:0] REG_WP0_X = 3'd0;
   localparam logic [2:0] REG_WP0_Y = 3'd1;
   localparam logic [2:0] REG_WP1_X = 3'd2;
   localparam logic [2:0] REG_WP1_Y = 3'd3;
   localparam logic [2:0] REG_WP2_X = 3'd4;
   localparam logic [2:0] REG_WP2_Y = 3'd5;
   localparam logic [2:0] REG_MAX_STEP = 3'd6;
   localparam logic [2:0] REG_MAX_TURN = 3'd7;

   typedef struct packed {
      logic [15:0]        dt_us;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] yaw;
   } req_word_type;

   typedef struct packed {
      logic               updated;
      logic signed [15:0] turn_cmd;
      logic [14:0]        step_cmd;
      logic [1:0]         waypoint_index;
      logic               finished;
   } rsp_word_type;

   // job handed from the front to the back
   typedef struct packed {
      logic               updated;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] yaw;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIST, ST_ATAN, ST_ERR, ST_COS, ST_FINAL, ST_OUT
   } back_state_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0:  r = 32'd536870912;
         5'd1:  r = 32'd316933406;
         5'd2:  r = 32'd167458907;
         5'd3:  r = 32'd85004756;
         5'd4:  r = 32'd42667331;
         5'd5:  r = 32'd21354465;
         5'd6:  r = 32'd10679838;
         5'd7:  r = 32'd5340245;
         5'd8:  r = 32'd2670163;
         5'd9:  r = 32'd1335087;
         5'd10: r = 32'd667544;
         5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;
         5'd13: r = 32'd83443;
         5'd14: r = 32'd41722;
         5'd15: r = 32'd20861;
         5'd16: r = 32'd10430;
         5'd17: r = 32'd5215;
         5'd18: r = 32'd2608;
         5'd19: r = 32'd1304;
         5'd20: r = 32'd652;
         5'd21: r = 32'd326;
         5'd22: r = 32'd163;
         5'd23: r = 32'd81;
         default: r = 32'd0;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

>>> src/waypoint_heading_guidance_unit.sv
// Top level of the waypoint heading guidance block.
// channel | direction | handshake        | payload
// req_    | in        | valid / stall    | req_word_type
// rsp_    | out       | valid / stall    | rsp_word_type
// csr_    | in        | valid / ready    | index 3 b, data 16 b
// A word with no update goes to ST_OUT; an update runs ST_DIST, then, unless the
// waypoint is near, CORDIC_STEPS atan2 and CORDIC_STEPS cosine iterations, then ST_OUT.
// Reset is synchronous; control and configuration registers take their reset values,
// datapath and queue storage registers need none.
// The two-entry queue lets the front take words while the back works or stalls.
`default_nettype none
module waypoint_heading_guidance_unit import wphg_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [15:0]  csr_data
);
   logic    push, full, not_empty, pop;
   job_type push_job, head;

   wphg_front u_front (.clock, .reset, .req_valid, .req_stall, .req_word,
      .job_valid(push), .job_full(full), .job(push_job));
   wphg_queue u_queue (.clock, .reset, .push, .push_job, .full, .not_empty,
      .pop, .head);
   wphg_back u_back (.clock, .reset, .job_avail(not_empty), .job(head),
      .job_pop(pop), .csr_valid, .csr_ready, .csr_index, .csr_data,
      .rsp_valid, .rsp_stall, .rsp_word);
endmodule
`default_nettype wire

>>> src/wphg_front.sv
// Front end: time accumulator and classification of each word.
`default_nettype none
module wphg_front import wphg_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              job_valid,
   input  wire logic         job_full,
   output job_type           job
);
   logic [17:0] accum_ff, accum_in;
   logic [18:0] sum;
   logic [17:0] sat;
   logic        upd;

   assign req_stall = job_full;
   assign job_valid = req_valid && !job_full;

   always_comb begin
      sum = {1'b0, accum_ff} + {3'b0, req_word.dt_us};
      sat = sum[18] ? ACCUM_MAX : sum[17:0];
      upd = sat > UPDATE_PERIOD;
      accum_in = upd ? sat - UPDATE_PERIOD : sat;
      job.updated = upd;
      job.pos_x = req_word.pos_x;
      job.pos_y = req_word.pos_y;
      job.yaw = req_word.yaw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff <= '0;
      end else if (job_valid) begin
         accum_ff <= accum_in;
      end
   end
endmodule
`default_nettype wire

>>> src/wphg_queue.sv
// Two-entry queue between the front and the back end.
`default_nettype none
module wphg_queue import wphg_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   output logic         not_empty,
   input  wire logic    pop,
   output job_type      head
);
   job_type    mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;

   assign full = cnt_ff == 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign head = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !not_empty |-> !pop) else $error("queue underflow");
   a_count: assert property (@(posedge clock) disable iff (reset)
      (push && !pop && !full) |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("queue count");
endmodule
`default_nettype wire

>>> src/wphg_back.sv
// Back end: distance test, waypoint advance and CORDIC guidance sequencer.
`default_nettype none
module wphg_back import wphg_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          job_avail,
   input  wire job_type       job,
   output logic               job_pop,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [2:0]    csr_index,
   input  wire logic [15:0]   csr_data,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output rsp_word_type       rsp_word
);
   back_state_type state_ff, state_in;
   logic [15:0] wp_ff [6];
   logic [14:0] max_step_ff, max_turn_ff;
   logic [1:0]  tgt_ff, tgt_in;
   logic        done_ff, done_in;
   logic signed [15:0] turn_ff, turn_in;
   logic [14:0] step_ff, step_in;
   logic        upd_ff, upd_in;
   logic signed [39:0] x_ff, x_in, y_ff, y_in;
   logic [31:0] z_ff, z_in;
   logic [StepW-1:0] i_ff, i_in;
   logic signed [16:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [15:0] err_ff, err_in;
   logic signed [15:0] yaw_ff, yaw_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic signed [39:0] xs, ys, xn, yn;
   logic [31:0] at;
   logic [15:0] theta;
   logic signed [33:0] prod, dsq;
   logic [32:0] d2;
   logic signed [34:0] tmul;
   logic signed [17:0] turn_w, mt;
   logic signed [40:0] cr;
   logic signed [25:0] cw;
   logic signed [15:0] csat;
   logic [30:0] sp;
   logic [1:0] t;
   logic [31:0] zc;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = '{updated: upd_ff, turn_cmd: turn_ff, step_cmd: step_ff,
                       waypoint_index: tgt_ff, finished: done_ff};

   always_comb begin
      state_in = state_ff;
      tgt_in = tgt_ff; done_in = done_ff; turn_in = turn_ff; step_in = step_ff;
      upd_in = upd_ff; x_in = x_ff; y_in = y_ff; z_in = z_ff; i_in = i_ff;
      dx_in = dx_ff; dy_in = dy_ff; err_in = err_ff; yaw_in = yaw_ff;
      rsp_valid_in = rsp_valid_ff;
      job_pop = 1'b0;
      t = (tgt_ff > 2'd2) ? 2'd2 : tgt_ff;
      xs = x_ff >>> i_ff;
      ys = y_ff >>> i_ff;
      at = atan_entry(5'(i_ff));
      xn = '0; yn = '0;
      prod = dx_ff * dx_ff;
      dsq = dy_ff * dy_ff;
      d2 = 33'(prod) + 33'(dsq);
      theta = 16'((z_ff + 32'h8000) >> 16);
      tmul = err_ff * GAIN_Q15 + 35'sd16384;
      turn_w = 18'(tmul >>> 15);
      mt = $signed({3'b0, max_turn_ff});
      cr = 41'(x_ff) + 41'sd16384;
      cw = 26'(cr >>> 15);
      csat = (cw > 26'sd32767) ? 16'sd32767 : (cw < -26'sd32768) ? -16'sd32768
             : 16'(cw);
      sp = 31'(max_step_ff * $unsigned(csat[14:0]) + 31'd16384);
      zc = {err_ff, 16'h0};
      case (state_ff)
         ST_IDLE: begin
            if (job_avail && (!rsp_valid_ff || !rsp_stall)) begin
               job_pop = 1'b1;
               upd_in = job.updated;
               yaw_in = job.yaw;
               dx_in = $signed({wp_ff[{t, 1'b0}][15], wp_ff[{t, 1'b0}]}) - job.pos_x;
               dy_in = $signed({wp_ff[{t, 1'b1}][15], wp_ff[{t, 1'b1}]}) - job.pos_y;
               rsp_valid_in = 1'b0;
               state_in = job.updated ? ST_DIST : ST_OUT;
            end else if (rsp_valid_ff && !rsp_stall) begin
               rsp_valid_in = 1'b0;
            end
         end
         ST_DIST: begin
            if (d2 < NEAR_SQ) begin
               if (tgt_ff < 2'(NUM_WAYPOINTS - 1)) tgt_in = tgt_ff + 2'd1;
               else done_in = 1'b1;
               state_in = ST_OUT;
            end else begin
               x_in = 40'(dx_ff) <<< 16;
               y_in = 40'(dy_ff) <<< 16;
               z_in = '0;
               if (dx_ff < 0) begin
                  x_in = -(40'(dx_ff) <<< 16);
                  y_in = -(40'(dy_ff) <<< 16);
                  z_in = 32'h8000_0000;
               end
               i_in = '0;
               state_in = ST_ATAN;
            end
         end
         ST_ATAN: begin
            if (y_ff >= 0) begin
               xn = x_ff + ys; yn = y_ff - xs; z_in = z_ff + at;
            end else begin
               xn = x_ff - ys; yn = y_ff + xs; z_in = z_ff - at;
            end
            x_in = xn; y_in = yn;
            i_in = i_ff + 1'b1;
            if (i_ff == StepW'(CORDIC_STEPS - 1)) state_in = ST_ERR;
         end
         ST_ERR: begin
            err_in = $signed(theta - yaw_ff);
            state_in = ST_COS;
            i_in = '0;
         end
         ST_COS: begin
            if (i_ff == '0) begin
               // turn from the error, and cosine start
               turn_in = (turn_w < -mt) ? 16'(-mt) : (turn_w > mt) ? 16'(mt)
                         : 16'(turn_w);
               x_in = CORDIC_K; y_in = '0; z_in = zc;
               if (zc > 32'h4000_0000 && zc < 32'hC000_0000) begin
                  x_in = -CORDIC_K; z_in = zc - 32'h8000_0000;
               end
               i_in = StepW'(1);
            end else begin
               if (!z_ff[31]) begin
                  xn = x_ff - (y_ff >>> (i_ff - 1'b1));
                  yn = y_ff + (x_ff >>> (i_ff - 1'b1));
                  z_in = z_ff - atan_entry(5'(i_ff - 1'b1));
               end else begin
                  xn = x_ff + (y_ff >>> (i_ff - 1'b1));
                  yn = y_ff - (x_ff >>> (i_ff - 1'b1));
                  z_in = z_ff + atan_entry(5'(i_ff - 1'b1));
               end
               x_in = xn; y_in = yn;
               i_in = i_ff + 1'b1;
               if (i_ff == StepW'(CORDIC_STEPS)) state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            step_in = (csat <= 0) ? 15'd0 : 15'(sp >> 15);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         tgt_ff <= '0;
         done_ff <= 1'b0;
         turn_ff <= 16'sd8192;
         step_ff <= 15'd16384;
         wp_ff[REG_WP0_X] <= 16'd500;
         wp_ff[REG_WP0_Y] <= 16'd0;
         wp_ff[REG_WP1_X] <= 16'd500;
         wp_ff[REG_WP1_Y] <= 16'd500;
         wp_ff[REG_WP2_X] <= 16'd250;
         wp_ff[REG_WP2_Y] <= -16'sd250;
         max_step_ff <= 15'd16384;
         max_turn_ff <= 15'd8192;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tgt_ff <= tgt_in;
         done_ff <= done_in;
         turn_ff <= turn_in;
         step_ff <= step_in;
         if (csr_valid) begin
            case (csr_index)
               REG_MAX_STEP: max_step_ff <= csr_data[14:0];
               REG_MAX_TURN: max_turn_ff <= csr_data[14:0];
               default: wp_ff[csr_index] <= csr_data;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      upd_ff <= upd_in; x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; i_ff <= i_in;
      dx_ff <= dx_in; dy_ff <= dy_in; err_ff <= err_in; yaw_ff <= yaw_in;
   end

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> state_ff == ST_IDLE) else $error("pop outside idle");
   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |=> rsp_valid_ff) else $error("result lost");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff && $stable(tgt_ff))
      else $error("stalled result changed");
endmodule
`default_nettype wire
